### hdl/audio_fractional_resampler_macros.svh
// assertion macros shared by the resampler rtl
`ifndef AUDIO_FRACTIONAL_RESAMPLER_MACROS_SVH
`define AUDIO_FRACTIONAL_RESAMPLER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled while in reset
`define AFR_ASSERT_IMPL(LBL, CLK, RSTN, ANT, CON) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |-> (CON)) \
    else $error("resampler assertion failed");
// next-cycle implication, disabled while in reset
`define AFR_ASSERT_NEXT(LBL, CLK, RSTN, ANT, CON) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |=> (CON)) \
    else $error("resampler assertion failed");
`else
`define AFR_ASSERT_IMPL(LBL, CLK, RSTN, ANT, CON)
`define AFR_ASSERT_NEXT(LBL, CLK, RSTN, ANT, CON)
`endif
`endif

### hdl/afr_pkg.sv
// shared types and constants of the fractional resampler
package afr_pkg;

  localparam int DEF_SAMPLE_BITS = 24;
  localparam int DEF_PHASE_BITS  = 16;
  localparam int WINDOW_TAPS     = 4;
  localparam int MAX_OUT         = 16;

  // lowpass taps in q.20
  localparam int COEF_FRAC = 20;
  localparam int GUARD     = 4;
  localparam int COEF_BITS = 20;
  localparam logic [COEF_BITS-1:0] NARROW_K0 = 20'd213631;
  localparam logic [COEF_BITS-1:0] NARROW_K1 = 20'd621386;
  localparam logic [COEF_BITS-1:0] WIDE_K0   = 20'd258473;
  localparam logic [COEF_BITS-1:0] WIDE_K1   = 20'd531628;

  // multiplier operand selection
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_K0P0,
    MUL_K1P1,
    MUL_K0P2,
    MUL_K0P1,
    MUL_K1P2,
    MUL_K0P3,
    MUL_CF,
    MUL_VF
  } mul_sel_t;

  // what the registered product feeds
  typedef enum logic [2:0] {
    USE_NONE,
    USE_S_LOAD,
    USE_S_ADD,
    USE_G0,
    USE_G1,
    USE_V_B,
    USE_V_A,
    USE_V_P1
  } use_sel_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    use_sel_t use_sel;
    logic     setup_cubic;
    logic     latch;
    logic     shift_in;
    logic     shift_new;
    logic     cubic;
    logic     wide;
  } ctrl_t;

  typedef struct packed {
    logic go;
    logic last;
  } emit_t;

endpackage

### hdl/afr_lane.sv
// one channel lane: sample window, shared multiplier and interpolation datapath
module afr_lane #(
  parameter int SAMPLE_BITS = afr_pkg::DEF_SAMPLE_BITS,
  parameter int PHASE_BITS  = afr_pkg::DEF_PHASE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  afr_pkg::ctrl_t                ctrl,
  input  logic [PHASE_BITS-1:0]         phase,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic signed [SAMPLE_BITS-1:0] res
);

  localparam int S    = SAMPLE_BITS;
  localparam int P    = PHASE_BITS;
  localparam int TAPS = afr_pkg::WINDOW_TAPS;
  localparam int W    = S + 6;
  localparam int KY   = afr_pkg::COEF_BITS + 1;
  localparam int YW   = (P + 1 > KY) ? P + 1 : KY;
  localparam int PW   = W + YW;
  localparam int SW   = S + 22;
  localparam int GS   = afr_pkg::COEF_FRAC - afr_pkg::GUARD;

  localparam logic signed [PW-1:0] HALF_P = PW'(1) << (P - 1);
  localparam logic signed [SW-1:0] HALF_G = SW'(1) << (GS - 1);
  localparam logic signed [W-1:0]  SAT_HI = W'({1'b0, {(S-1){1'b1}}});
  localparam logic signed [W-1:0]  SAT_LO = -SAT_HI - W'(1);
  localparam logic signed [W-1:0]  RND_C  = W'(1);
  localparam logic signed [W-1:0]  RND_F  = W'(1) << (afr_pkg::GUARD - 1);

  logic signed [S-1:0]  win_r [TAPS];
  logic signed [S-1:0]  new_r;
  logic signed [W-1:0]  ca_r, cb_r, cc_r, v_r;
  logic signed [SW-1:0] s_r;
  logic signed [PW-1:0] prod_r;

  logic signed [W-1:0]  p0, p1, p2, p3;
  logic signed [W-1:0]  ca_nxt, cb_nxt, cc_nxt;
  logic signed [W-1:0]  mx;
  logic signed [YW-1:0] my, k0_y, k1_y, f_y;
  logic signed [PW-1:0] prod_nxt, rp_full;
  logic signed [W-1:0]  rnd_w, g_w;
  logic signed [SW-1:0] gs_full;
  logic signed [W-1:0]  rv_full, rv;

  assign p0 = W'(win_r[0]);
  assign p1 = W'(win_r[1]);
  assign p2 = W'(win_r[2]);
  assign p3 = W'(win_r[3]);

  // catmull-rom polynomial coefficients
  assign ca_nxt = p2 - p0;
  assign cb_nxt = (p0 <<< 1) - ((p1 <<< 2) + p1) + (p2 <<< 2) - p3;
  assign cc_nxt = (p3 - p0) + ((p1 - p2) <<< 1) + (p1 - p2);

  assign k0_y = YW'({1'b0, ctrl.wide ? afr_pkg::WIDE_K0 : afr_pkg::NARROW_K0});
  assign k1_y = YW'({1'b0, ctrl.wide ? afr_pkg::WIDE_K1 : afr_pkg::NARROW_K1});
  assign f_y  = YW'({1'b0, phase});

  always_comb begin
    mx = '0;
    my = '0;
    case (ctrl.mul_sel)
      afr_pkg::MUL_K0P0: begin mx = p0; my = k0_y; end
      afr_pkg::MUL_K1P1: begin mx = p1; my = k1_y; end
      afr_pkg::MUL_K0P2: begin mx = p2; my = k0_y; end
      afr_pkg::MUL_K0P1: begin mx = p1; my = k0_y; end
      afr_pkg::MUL_K1P2: begin mx = p2; my = k1_y; end
      afr_pkg::MUL_K0P3: begin mx = p3; my = k0_y; end
      afr_pkg::MUL_CF:   begin mx = cc_r; my = f_y; end
      afr_pkg::MUL_VF:   begin mx = v_r; my = f_y; end
      default: begin end
    endcase
  end

  assign prod_nxt = PW'(mx) * PW'(my);

  // round half up, drop phase fraction bits
  assign rp_full = prod_r + HALF_P;
  assign rnd_w   = rp_full[P +: W];

  // filter sum down to guard bits
  assign gs_full = s_r + HALF_G;
  assign g_w     = gs_full[GS +: W];

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (ctrl.latch) begin
      new_r <= in_sample;
    end
    if (ctrl.setup_cubic) begin
      ca_r <= ca_nxt;
      cb_r <= cb_nxt;
      cc_r <= cc_nxt;
    end
    case (ctrl.use_sel)
      afr_pkg::USE_S_LOAD: s_r <= prod_r[SW-1:0];
      afr_pkg::USE_S_ADD:  s_r <= s_r + prod_r[SW-1:0];
      afr_pkg::USE_G0: begin
        ca_r <= g_w;
        s_r  <= prod_r[SW-1:0];
      end
      afr_pkg::USE_G1:     cc_r <= g_w - ca_r;
      afr_pkg::USE_V_B:    v_r <= cb_r + rnd_w;
      afr_pkg::USE_V_A:    v_r <= ca_r + rnd_w;
      afr_pkg::USE_V_P1:   v_r <= (p1 <<< 1) + rnd_w;
      default: begin end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) begin
        win_r[i] <= '0;
      end
    end else if (ctrl.shift_in || ctrl.shift_new) begin
      for (int i = 0; i < TAPS - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[TAPS-1] <= ctrl.shift_in ? in_sample : new_r;
    end
  end

  // final rounding and saturation
  assign rv_full = v_r + (ctrl.cubic ? RND_C : RND_F);
  assign rv      = ctrl.cubic ? (rv_full >>> 1) : (rv_full >>> afr_pkg::GUARD);

  always_comb begin
    if (rv > SAT_HI) begin
      res = SAT_HI[S-1:0];
    end else if (rv < SAT_LO) begin
      res = SAT_LO[S-1:0];
    end else begin
      res = rv[S-1:0];
    end
  end

endmodule

### hdl/afr_seq.sv
// sequencer: ratio register, phase and skip tracking, lane microprogram
`include "audio_fractional_resampler_macros.svh"

module afr_seq #(
  parameter int PHASE_BITS = afr_pkg::DEF_PHASE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [PHASE_BITS+1:0] cfg_delta_ratio,
  input  logic                  out_free,
  output afr_pkg::ctrl_t        ctrl,
  output afr_pkg::emit_t        emit,
  output logic [PHASE_BITS-1:0] phase
);

  localparam int P      = PHASE_BITS;
  localparam int DW     = P + 2;
  localparam int CNT_W  = $clog2(afr_pkg::MAX_OUT);
  localparam int STEP_W = 3;

  localparam logic [DW-1:0] RATIO_ONE = DW'(1) << P;
  localparam logic [DW-1:0] CUBIC_LIM = DW'(5) << (P - 2);
  localparam logic [DW-1:0] WIDE_LIM  = DW'(2) << P;

  // index of the last word a single input may cause
  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(afr_pkg::MAX_OUT - 1);

  localparam logic [STEP_W-1:0] SETUP_LAST_CUBIC = 3'd0;
  localparam logic [STEP_W-1:0] SETUP_LAST_FILT  = 3'd7;
  localparam logic [STEP_W-1:0] CALC_LAST_CUBIC  = 3'd5;
  localparam logic [STEP_W-1:0] CALC_LAST_FILT   = 3'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_CALC,
    ST_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [DW-1:0]       delta_r;
  logic [P-1:0]        phase_r, phase_nxt;
  logic [2:0]          skip_r, skip_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;

  logic                mode_cubic, mode_wide;
  logic [DW:0]         sum;
  logic [2:0]          carry;
  logic                run_last;
  logic [STEP_W-1:0]   setup_last, calc_last;

  assign mode_cubic = delta_r < CUBIC_LIM;
  assign mode_wide  = delta_r >= WIDE_LIM;
  assign setup_last = mode_cubic ? SETUP_LAST_CUBIC : SETUP_LAST_FILT;
  assign calc_last  = mode_cubic ? CALC_LAST_CUBIC : CALC_LAST_FILT;

  assign sum      = {{(DW+1-P){1'b0}}, phase_r} + {1'b0, delta_r};
  assign carry    = sum[P +: 3];
  assign run_last = (carry != 3'd0) || (cnt_r == CNT_CAP);

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign phase     = phase_r;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    skip_nxt  = skip_r;
    cnt_nxt   = cnt_r;
    step_nxt  = step_r;

    ctrl.mul_sel     = afr_pkg::MUL_NONE;
    ctrl.use_sel     = afr_pkg::USE_NONE;
    ctrl.setup_cubic = 1'b0;
    ctrl.latch       = 1'b0;
    ctrl.shift_in    = 1'b0;
    ctrl.shift_new   = 1'b0;
    ctrl.cubic       = mode_cubic;
    ctrl.wide        = mode_wide;
    emit.go          = 1'b0;
    emit.last        = run_last;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (skip_r != 3'd0) begin
            // pending skip: sample goes straight into the window
            ctrl.shift_in = 1'b1;
            skip_nxt      = skip_r - 3'd1;
          end else begin
            ctrl.latch = 1'b1;
            cnt_nxt    = '0;
            step_nxt   = '0;
            state_nxt  = ST_SETUP;
          end
        end
      end

      ST_SETUP: begin
        if (mode_cubic) begin
          ctrl.setup_cubic = 1'b1;
        end else begin
          // two 3-tap sums through one multiplier, then guard rounding
          case (step_r)
            3'd0: ctrl.mul_sel = afr_pkg::MUL_K0P0;
            3'd1: begin
              ctrl.mul_sel = afr_pkg::MUL_K1P1;
              ctrl.use_sel = afr_pkg::USE_S_LOAD;
            end
            3'd2: begin
              ctrl.mul_sel = afr_pkg::MUL_K0P2;
              ctrl.use_sel = afr_pkg::USE_S_ADD;
            end
            3'd3: begin
              ctrl.mul_sel = afr_pkg::MUL_K0P1;
              ctrl.use_sel = afr_pkg::USE_S_ADD;
            end
            3'd4: begin
              ctrl.mul_sel = afr_pkg::MUL_K1P2;
              ctrl.use_sel = afr_pkg::USE_G0;
            end
            3'd5: begin
              ctrl.mul_sel = afr_pkg::MUL_K0P3;
              ctrl.use_sel = afr_pkg::USE_S_ADD;
            end
            3'd6: ctrl.use_sel = afr_pkg::USE_S_ADD;
            3'd7: ctrl.use_sel = afr_pkg::USE_G1;
            default: begin end
          endcase
        end
        if (step_r == setup_last) begin
          step_nxt  = '0;
          state_nxt = ST_CALC;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end

      ST_CALC: begin
        if (mode_cubic) begin
          // horner: multiply, then round and add the next coefficient
          case (step_r)
            3'd0: ctrl.mul_sel = afr_pkg::MUL_CF;
            3'd1: ctrl.use_sel = afr_pkg::USE_V_B;
            3'd2: ctrl.mul_sel = afr_pkg::MUL_VF;
            3'd3: ctrl.use_sel = afr_pkg::USE_V_A;
            3'd4: ctrl.mul_sel = afr_pkg::MUL_VF;
            3'd5: ctrl.use_sel = afr_pkg::USE_V_P1;
            default: begin end
          endcase
        end else begin
          case (step_r)
            3'd0: ctrl.mul_sel = afr_pkg::MUL_CF;
            3'd1: ctrl.use_sel = afr_pkg::USE_V_A;
            default: begin end
          endcase
        end
        if (step_r == calc_last) begin
          step_nxt  = '0;
          state_nxt = ST_EMIT;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          emit.go   = 1'b1;
          phase_nxt = sum[P-1:0];
          if (run_last) begin
            ctrl.shift_new = 1'b1;
            skip_nxt       = (carry != 3'd0) ? carry - 3'd1 : 3'd0;
            state_nxt      = ST_IDLE;
          end else begin
            cnt_nxt   = cnt_r + CNT_W'(1);
            state_nxt = ST_CALC;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      delta_r <= RATIO_ONE;
      phase_r <= '0;
      skip_r  <= '0;
      cnt_r   <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      skip_r  <= skip_nxt;
      cnt_r   <= cnt_nxt;
      step_r  <= step_nxt;
      if (cfg_valid && cfg_ready) begin
        delta_r <= cfg_delta_ratio;
      end
    end
  end

  `AFR_ASSERT_IMPL(a_busy_no_skip, clk, rst_n, state_r != ST_IDLE, skip_r == 3'd0)
  `AFR_ASSERT_IMPL(a_cap_ends_run, clk, rst_n, emit.go && cnt_r == CNT_CAP, emit.last)
  `AFR_ASSERT_IMPL(a_emit_free, clk, rst_n, emit.go, out_free && state_r == ST_EMIT)
  `AFR_ASSERT_NEXT(a_last_to_idle, clk, rst_n, emit.go && emit.last, state_r == ST_IDLE)
  `AFR_ASSERT_NEXT(a_phase_holds, clk, rst_n, state_r != ST_EMIT, $stable(phase_r))

endmodule

### hdl/audio_fractional_resampler.sv
// top level of the stereo fractional resampler
//
// Stereo resampler with a ratio register (unsigned q2.16 input step per
// output word). Below a ratio of 1.25 each output is a catmull-rom cubic
// interpolation between the two middle samples of a four-sample window; at
// 1.25 and above it is a phase blend of two 3-tap lowpass sums, with the
// wider filter from 2.0 up. Left and right run in two identical lanes, each
// with one multiplier that is reused step by step, and a merge register
// pairs the lane results into one output word with the last-of-run flag.
// When skips are pending, an input word goes straight into the window and
// gives no output; otherwise it gives n output words (1..16). The lane
// multiplier sets the pace: a cubic output needs three dependent
// multiply/round steps, a filter output one, and filter mode first builds
// its two tap sums in a setup phase. A run also waits while the output side
// stalls. Input is stalled while a run is in flight; the ratio register
// takes writes only while the block is idle.

module audio_fractional_resampler #(
  parameter int SAMPLE_BITS = afr_pkg::DEF_SAMPLE_BITS,
  parameter int PHASE_BITS  = afr_pkg::DEF_PHASE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input words
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_left,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_right,
  // output words
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_left,
  output logic signed [SAMPLE_BITS-1:0] out_right,
  output logic                          out_last_of_run,
  // ratio register
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [PHASE_BITS+1:0]         cfg_delta_ratio
);

  afr_pkg::ctrl_t           ctrl;
  afr_pkg::emit_t           emit;
  logic [PHASE_BITS-1:0]    phase;
  logic                     out_free;
  logic signed [SAMPLE_BITS-1:0] res_left, res_right;

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_left_r, out_right_r;
  logic                          out_last_r;

  // merge register can take a new word when empty or being drained
  assign out_free = !out_valid_r || !out_stall;

  // control: phase accumulator, skip count, per-step lane commands
  afr_seq #(
    .PHASE_BITS (PHASE_BITS)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_delta_ratio (cfg_delta_ratio),
    .out_free        (out_free),
    .ctrl            (ctrl),
    .emit            (emit),
    .phase           (phase)
  );

  // left lane
  afr_lane #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .PHASE_BITS  (PHASE_BITS)
  ) u_lane_left (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .phase     (phase),
    .in_sample (in_sample_left),
    .res       (res_left)
  );

  afr_lane #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .PHASE_BITS  (PHASE_BITS)
  ) u_lane_right (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .phase     (phase),
    .in_sample (in_sample_right),
    .res       (res_right)
  );

  // merge stage: pair both lane results into one held output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.go) begin
      out_left_r  <= res_left;
      out_right_r <= res_right;
      out_last_r  <= emit.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_left        = out_left_r;
  assign out_right       = out_right_r;
  assign out_last_of_run = out_last_r;

endmodule

### tb/sv/resample_checker.sv
// checker for the fractional resampler: predicts every output word and compares it
module resample_checker #(
  parameter int SAMPLE_BITS = afr_pkg::DEF_SAMPLE_BITS,
  parameter int PHASE_BITS  = afr_pkg::DEF_PHASE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_left,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_right,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [SAMPLE_BITS-1:0] out_left,
  input  logic signed [SAMPLE_BITS-1:0] out_right,
  input  logic                          out_last_of_run,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [PHASE_BITS+1:0]         cfg_delta_ratio,
  output int                            mismatches,
  output int                            words_pending
);

  localparam int TAPS    = afr_pkg::WINDOW_TAPS;
  localparam int RUN_MAX = afr_pkg::MAX_OUT;

  // 3-tap lowpass taps in q.20, gain folded in
  localparam longint NARROW_OUTER = 213631;
  localparam longint NARROW_MID   = 621386;
  localparam longint WIDE_OUTER   = 258473;
  localparam longint WIDE_MID     = 531628;
  localparam int     TAP_FRAC     = 20;
  localparam int     GUARD_BITS   = 4;

  localparam int unsigned CUBIC_BELOW  = 5 << (PHASE_BITS - 2);
  localparam int unsigned NARROW_BELOW = 2 << PHASE_BITS;

  localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

  typedef enum logic [1:0] {
    MODE_CUBIC,
    MODE_NARROW,
    MODE_WIDE
  } lane_mode_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic                          last;
  } out_word_t;

  logic signed [SAMPLE_BITS-1:0] win_left  [TAPS];
  logic signed [SAMPLE_BITS-1:0] win_right [TAPS];
  logic [PHASE_BITS-1:0]         frac_phase;
  logic [2:0]                    skips_left;
  logic [PHASE_BITS+1:0]         ratio;
  out_word_t                     expected_words [$];

  initial begin
    mismatches    = 0;
    words_pending = 0;
  end

  // floor((y + half) / 2^s)
  function automatic longint round_shift(input longint y, input int s);
    return (y + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] clip_sample(input longint v);
    if (v > SAMPLE_MAX) return SAMPLE_BITS'(SAMPLE_MAX);
    if (v < SAMPLE_MIN) return SAMPLE_BITS'(SAMPLE_MIN);
    return SAMPLE_BITS'(v);
  endfunction

  function automatic longint catmull_rom(input longint p0, p1, p2, p3, f);
    longint a, b, c, v2, v1, v0;
    a  = p2 - p0;
    b  = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    c  = (p3 - p0) + 3 * (p1 - p2);
    v2 = b + round_shift(c * f, PHASE_BITS);
    v1 = a + round_shift(v2 * f, PHASE_BITS);
    v0 = 2 * p1 + round_shift(v1 * f, PHASE_BITS);
    return round_shift(v0, 1);
  endfunction

  function automatic longint lowpass_blend(input longint p0, p1, p2, p3, f,
                                           input longint k_out, k_mid);
    longint s0, s1, g0, g1, v;
    s0 = k_out * p0 + k_mid * p1 + k_out * p2;
    s1 = k_out * p1 + k_mid * p2 + k_out * p3;
    g0 = round_shift(s0, TAP_FRAC - GUARD_BITS);
    g1 = round_shift(s1, TAP_FRAC - GUARD_BITS);
    v  = g0 + round_shift((g1 - g0) * f, PHASE_BITS);
    return round_shift(v, GUARD_BITS);
  endfunction

  function automatic lane_mode_t mode_for(input logic [PHASE_BITS+1:0] r);
    if (r < CUBIC_BELOW) return MODE_CUBIC;
    if (r < NARROW_BELOW) return MODE_NARROW;
    return MODE_WIDE;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] lane_point(input lane_mode_t mode,
                                                              input longint p0, p1, p2, p3,
                                                              input longint f);
    case (mode)
      MODE_CUBIC:  return clip_sample(catmull_rom(p0, p1, p2, p3, f));
      MODE_NARROW: return clip_sample(lowpass_blend(p0, p1, p2, p3, f, NARROW_OUTER,
                                                    NARROW_MID));
      default:     return clip_sample(lowpass_blend(p0, p1, p2, p3, f, WIDE_OUTER,
                                                    WIDE_MID));
    endcase
  endfunction

  // output words caused by one input word, then the window shift
  task automatic predict_run(input logic signed [SAMPLE_BITS-1:0] new_left,
                             input logic signed [SAMPLE_BITS-1:0] new_right);
    int                  skip_acc;
    int                  n;
    logic [PHASE_BITS+2:0] sum;
    out_word_t           w;
    lane_mode_t          mode;
    mode     = mode_for(ratio);
    skip_acc = skips_left;
    n        = 0;
    while (skip_acc == 0 && n < RUN_MAX) begin
      w.left  = lane_point(mode, win_left[0], win_left[1], win_left[2], win_left[3],
                           longint'(frac_phase));
      w.right = lane_point(mode, win_right[0], win_right[1], win_right[2], win_right[3],
                           longint'(frac_phase));
      w.last  = 1'b0;
      expected_words.push_back(w);
      sum        = (PHASE_BITS+3)'(frac_phase) + (PHASE_BITS+3)'(ratio);
      skip_acc  += int'(sum[PHASE_BITS+2:PHASE_BITS]);
      frac_phase = sum[PHASE_BITS-1:0];
      n++;
    end
    if (n > 0) begin
      w      = expected_words.pop_back();
      w.last = 1'b1;
      expected_words.push_back(w);
    end
    for (int i = 0; i < TAPS - 1; i++) begin
      win_left[i]  = win_left[i+1];
      win_right[i] = win_right[i+1];
    end
    win_left[TAPS-1]  = new_left;
    win_right[TAPS-1] = new_right;
    if (skip_acc > 0) skip_acc--;
    skips_left    = skip_acc[2:0];
    words_pending = expected_words.size();
  endtask

  task automatic check_word();
    out_word_t w;
    if (expected_words.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected output word, expected none, actual %0d %0d last %0b",
               $time, out_left, out_right, out_last_of_run);
      return;
    end
    w = expected_words.pop_front();
    words_pending = expected_words.size();
    if (out_left !== w.left) begin
      mismatches++;
      $display("%0t: out_left expected %0d, actual %0d", $time, $signed(w.left),
               out_left);
    end
    if (out_right !== w.right) begin
      mismatches++;
      $display("%0t: out_right expected %0d, actual %0d", $time, $signed(w.right),
               out_right);
    end
    if (out_last_of_run !== w.last) begin
      mismatches++;
      $display("%0t: out_last_of_run expected %0b, actual %0b", $time, w.last,
               out_last_of_run);
    end
  endtask

  // output pops before input pushes: a word can never answer its own input
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) begin
        win_left[i]  = '0;
        win_right[i] = '0;
      end
      frac_phase = '0;
      skips_left = '0;
      ratio      = (PHASE_BITS+2)'(1) << PHASE_BITS;
      expected_words.delete();
      words_pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) ratio = cfg_delta_ratio;
      if (out_valid && !out_stall) check_word();
      if (in_valid && !in_stall) predict_run(in_sample_left, in_sample_right);
    end
  end

endmodule

### tb/sv/tb_top.sv
// top of the resampler testbench: clock, reset, stimulus and verdict
module tb_top;

  localparam int SB = afr_pkg::DEF_SAMPLE_BITS;
  localparam int PB = afr_pkg::DEF_PHASE_BITS;

  // settle time, long enough for the longest run of 16 cubic words
  localparam int SETTLE_CYCLES = 150;

  // ratio settings walked in order, extremes and mode boundaries first
  localparam int FIXED_PHASES  = 9;
  localparam int RANDOM_PHASES = 5;
  localparam int RANDOM_ITEMS  = 20;
  localparam int CORNERS       = 8;

  localparam logic signed [SB-1:0] FULL_POS = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] FULL_NEG = {1'b1, {(SB-1){1'b0}}};

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [SB-1:0] in_sample_left;
  logic signed [SB-1:0] in_sample_right;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [SB-1:0] out_left;
  logic signed [SB-1:0] out_right;
  logic                 out_last_of_run;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [PB+1:0]        cfg_delta_ratio;
  int                   mismatches;
  int                   words_pending;

  // idle rates in percent per cycle, changed phase by phase
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // reset value first (no write), then: ratio floor, ratio ceiling,
  // top of cubic, bottom of narrow, top of narrow, bottom of wide,
  // just under 1/16 and zero, where each input gets the full 16 words
  int fixed_ratio [FIXED_PHASES] = '{65536, 4096, 262143, 81919, 81920,
                                     131071, 131072, 4095, 0};
  int fixed_items [FIXED_PHASES] = '{20, 12, 25, 20, 20, 15, 15, 6, 4};

  // full-scale swings to drive the cubic overshoot and the filters into saturation
  logic signed [SB-1:0] corner_left  [CORNERS];
  logic signed [SB-1:0] corner_right [CORNERS];

  audio_fractional_resampler uut (.*);

  resample_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure, drawn fresh every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // mostly raw random words, with extremes and near-zero values mixed in
  function automatic logic signed [SB-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return FULL_POS;
      1:       return FULL_NEG;
      2:       return SB'(int'($urandom_range(511)) - 256);
      default: return SB'($urandom());
    endcase
  endfunction

  // one ratio from a randomly chosen mode range, including the too-small region
  function automatic logic [PB+1:0] pick_ratio();
    case ($urandom_range(3))
      0:       return (PB+2)'($urandom_range(81919, 4096));
      1:       return (PB+2)'($urandom_range(131071, 81920));
      2:       return (PB+2)'($urandom_range(262143, 131072));
      default: return (PB+2)'($urandom_range(4095, 0));
    endcase
  endfunction

  // hold the word until the block takes it; gaps only before a new word
  task automatic send_word(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_left  <= l;
    in_sample_right <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop sending until every predicted word is out, then let a word with no
  // output finish inside the block before anything else happens
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_ratio(input logic [PB+1:0] r);
    cfg_valid       <= 1'b1;
    cfg_delta_ratio <= r;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int            ph;
    int            k;
    int            count;
    logic [PB+1:0] ratio_now;

    in_valid        <= 1'b0;
    in_sample_left  <= '0;
    in_sample_right <= '0;
    cfg_valid       <= 1'b0;
    cfg_delta_ratio <= (PB+2)'(65536);
    rst_n           <= 1'b0;

    corner_left  = '{FULL_POS, FULL_NEG, FULL_POS, FULL_NEG, FULL_POS, FULL_POS,
                     FULL_NEG, '0};
    corner_right = '{FULL_NEG, FULL_POS, FULL_NEG, FULL_POS, FULL_NEG, FULL_NEG,
                     FULL_POS, '1};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (ph = 0; ph < FIXED_PHASES + RANDOM_PHASES; ph++) begin
      if (ph < FIXED_PHASES) begin
        ratio_now = (PB+2)'(fixed_ratio[ph]);
        count     = fixed_items[ph];
      end else begin
        ratio_now = pick_ratio();
        count     = RANDOM_ITEMS;
      end
      // the first phase runs on the reset ratio; later ones write while idle
      if (ph > 0) write_ratio(ratio_now);

      // rotate through quiet, sender gaps, receiver stalls and both at once
      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 57;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 57;
        end
        default: begin
          send_idle_pct  = 9;
          recv_stall_pct = 9;
        end
      endcase

      for (k = 0; k < count; k++) begin
        // full-scale swings once in each of wide, cubic and narrow mode
        if (ph >= 2 && ph <= 4 && k < CORNERS)
          send_word(corner_left[k], corner_right[k]);
        else
          send_word(pick_sample(), pick_sample());
        // mid-stream pause until the output side has caught up
        if (ph[0] && k == count / 2) drain_and_settle();
      end
      drain_and_settle();
    end

    if (mismatches == 0 && words_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #6000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### audio_fractional_resampler.f
+incdir+hdl
hdl/afr_pkg.sv
hdl/afr_lane.sv
hdl/afr_seq.sv
hdl/audio_fractional_resampler.sv
tb/sv/resample_checker.sv
tb/sv/tb_top.sv
